[rtl/aes_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES package
// Shared types, S-box tables and GF(2^8) helpers for the AES-128 pipeline.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned BlockW  = 128;
  localparam int unsigned HalfW   = 64;
  localparam int unsigned NumRnd  = 10;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CFG_KEY_HIGH = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_LOW  = 1'b1;

  localparam logic REQ_ENCRYPT = 1'b0;
  localparam logic REQ_DECRYPT = 1'b1;

  typedef logic [BlockW-1:0] block_t;
  typedef logic [7:0]        byte_t;

  function automatic byte_t xtime(input byte_t a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic byte_t gmul(input byte_t a, input byte_t b);
    byte_t p;
    byte_t x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    gmul = p;
  endfunction

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam byte_t INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam byte_t RCON [NumRnd] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // Byte n of a block sits in bits 127-8n downto 120-8n.
  function automatic byte_t get_b(input block_t s, input int n);
    get_b = s[BlockW-1-8*n -: 8];
  endfunction

  function automatic block_t sub_shift(input block_t s);
    block_t o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        o[BlockW-1-8*(4*c+r) -: 8] = SBOX[get_b(s, 4*((c+r)%4)+r)];
    sub_shift = o;
  endfunction

  function automatic block_t inv_sub_shift(input block_t s);
    block_t o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        o[BlockW-1-8*(4*((c+r)%4)+r) -: 8] = INV_SBOX[get_b(s, 4*c+r)];
    inv_sub_shift = o;
  endfunction

  function automatic block_t mix_cols(input block_t s, input logic inv);
    block_t o;
    byte_t  m0, m1, m2, m3;
    m0 = inv ? 8'd14 : 8'd2;
    m1 = inv ? 8'd11 : 8'd3;
    m2 = inv ? 8'd13 : 8'd1;
    m3 = inv ? 8'd9  : 8'd1;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        o[BlockW-1-8*(4*c+r) -: 8] =
          gmul(get_b(s, 4*c+r), m0) ^ gmul(get_b(s, 4*c+(r+1)%4), m1) ^
          gmul(get_b(s, 4*c+(r+2)%4), m2) ^ gmul(get_b(s, 4*c+(r+3)%4), m3);
    mix_cols = o;
  endfunction

  // One step of the key expansion: round key k gives round key k+1.
  function automatic block_t next_key(input block_t k, input byte_t rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

endpackage

[rtl/aes_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES channel interfaces
// Valid/ready channels for blocks in, blocks out and key writes.
// ----------------------------------------------------------------------------
interface aes_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [63:0] block_high;
  logic [63:0] block_low;
  modport source (output valid, req_type, block_high, block_low, input ready);
  modport sink   (input valid, req_type, block_high, block_low, output ready);
endinterface

interface aes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_high;
  logic [63:0] out_low;
  modport source (output valid, out_high, out_low, input ready);
  modport sink   (input valid, out_high, out_low, output ready);
endinterface

interface aes_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/aes_keysched.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES key schedule
// Holds the key registers and expands them into eleven round keys, one
// registered step per cycle after each key write.
// ----------------------------------------------------------------------------
module aes_keysched
  import aes_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  aes_cfg_if.sink cfg,
  output block_t rk_o [NumRnd+1],
  output logic   rk_rdy_o
);

  // Cycles from a key write until the last round key is valid for a new block.
  localparam logic [3:0] SettleCyc = 4'(NumRnd + 1);

  logic [HalfW-1:0] key_high_r, key_low_r;
  block_t           rk_r [NumRnd+1];
  logic [3:0]       settle_r;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_KEY_HIGH: key_high_r <= cfg.data;
        CFG_KEY_LOW:  key_low_r  <= cfg.data;
        default: ;
      endcase
    end
  end

  // Expansion settles one round key per cycle.
  always_ff @(posedge clk) begin
    rk_r[0] <= {key_high_r, key_low_r};
    for (int k = 0; k < NumRnd; k++) rk_r[k+1] <= next_key(rk_r[k], RCON[k]);
  end

  // Hold off new blocks until a fresh key has reached every round key stage.
  always_ff @(posedge clk) begin
    if (!rst_n) settle_r <= SettleCyc;
    else if (cfg.valid) settle_r <= SettleCyc;
    else if (settle_r != 4'd0) settle_r <= settle_r - 4'd1;
  end

  assign rk_o     = rk_r;
  assign rk_rdy_o = (settle_r == 4'd0);

endmodule

[rtl/aes128_block_cipher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block cipher
// Encrypts or decrypts one 128-bit block per cycle, barring stalls, through a round pipeline.
// ----------------------------------------------------------------------------
// Pipeline: input transaction to result through one input stage, ten round
// stages and one output register, held only under back-pressure.
// Throughput: one block per cycle while not stalled, set by one registered round per stage.
// Reset (synchronous, rst_n low) clears valid bits and both key registers.
// Input is refused after reset and after each key write while
// the round keys run through the expansion stages.
module aes128_block_cipher
  import aes_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  aes_in_if.sink    in_ch,
  aes_out_if.source out_ch,
  aes_cfg_if.sink   cfg_ch
);

  localparam int unsigned Stg = NumRnd + 1;

  block_t rk [NumRnd+1];
  block_t st_r    [Stg];
  logic   dec_r   [Stg];
  logic   vld_r   [Stg];
  block_t res_r;
  logic   res_vld_r;
  logic   adv;
  logic   keys_rdy;

  aes_keysched u_keys (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_ch),
    .rk_o    (rk),
    .rk_rdy_o(keys_rdy)
  );

  // Whole pipe moves together; it advances whenever the output slot frees.
  // Hold off new blocks while the round keys settle.
  assign adv         = !res_vld_r || out_ch.ready;
  assign in_ch.ready = adv && keys_rdy;

  // Stage 0: initial add of the first (or last, for decrypt) round key.
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else if (adv) vld_r[0] <= in_ch.valid && keys_rdy;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dec_r[0] <= in_ch.req_type;
      st_r[0]  <= {in_ch.block_high, in_ch.block_low} ^
                  (in_ch.req_type == REQ_DECRYPT ? rk[NumRnd] : rk[0]);
    end
  end

  // Round stages. Decrypt uses the direct inverse order: inverse shift/sub,
  // add key, inverse mix (the last round skips the mix).
  for (genvar g = 1; g < Stg; g++) begin : g_rnd
    block_t enc_v, dec_v;
    always_comb begin
      enc_v = sub_shift(st_r[g-1]);
      if (g != NumRnd) enc_v = mix_cols(enc_v, 1'b0);
      enc_v = enc_v ^ rk[g];
      dec_v = inv_sub_shift(st_r[g-1]) ^ rk[NumRnd-g];
      if (g != NumRnd) dec_v = mix_cols(dec_v, 1'b1);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[g] <= 1'b0;
      else if (adv) vld_r[g] <= vld_r[g-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dec_r[g] <= dec_r[g-1];
        st_r[g]  <= (dec_r[g-1] == REQ_DECRYPT) ? dec_v : enc_v;
      end
    end
  end

  // Output register: hold while the sink stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) res_vld_r <= 1'b0;
    else if (adv) res_vld_r <= vld_r[Stg-1];
  end

  always_ff @(posedge clk) begin
    if (adv) res_r <= st_r[Stg-1];
  end

  assign out_ch.valid    = res_vld_r;
  assign out_ch.out_high = res_r[BlockW-1:HalfW];
  assign out_ch.out_low  = res_r[HalfW-1:0];

  // A stalled result must hold its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(res_r))
    else $error("result changed under stall");

  // A valid in the last round stage reaches the output register on advance.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vld_r[Stg-1] |=> out_ch.valid)
    else $error("result lost at output");

  // Accepted input shows as valid at stage 0.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[0])
    else $error("input transaction dropped");

endmodule
